/* rtl/core/apq_pkg.sv */
// types and constants shared by the array priority queue
package apq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W = 32;
  localparam int unsigned PRI_W = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_e;

  typedef struct packed {
    op_e                      opcode;
    logic signed [VAL_W-1:0]  value;
    logic signed [PRI_W-1:0]  priority_req;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [VAL_W-1:0]  removed_value;
    logic [CNT_W-1:0]         entry_count;
  } rsp_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic signed [PRI_W-1:0]  prio;
  } entry_t;

endpackage

/* rtl/core/array_priority_queue.sv */
// unsorted array priority queue with a sequential max scan and shift-down
// insert, full insert and empty remove give the result in the cycle after start is accepted
// remove scans all held entries for the top priority, then shifts the ones above it down
// the entry memory does one read and one write per cycle, scan then shift
// busy stays high for the whole remove; the next beat may start the cycle after busy falls
// reset clears the count and control; entry memory holds no reset value
module array_priority_queue import apq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output rsp_t rsp_o
);

  entry_t mem [DEPTH];

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic signed [PRI_W-1:0] best_pri_q, best_pri_d;
  logic signed [VAL_W-1:0] best_val_q, best_val_d;
  entry_t           rd_q;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  logic             accept;
  logic             take;
  logic             last_scan;
  logic             last_shift;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  assign accept     = start && (state_q == ST_IDLE);
  assign take       = (idx_q == '0) || (rd_q.prio > best_pri_q);
  assign last_scan  = ({1'b0, idx_q} == CNT_W'(cnt_q - CNT_W'(1)));
  assign last_shift = (CNT_W'({1'b0, idx_q} + CNT_W'(1)) >= cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && req_i.opcode == OP_REMOVE && cnt_q != '0) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_scan) state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (last_shift) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    best_idx_d = best_idx_q;
    best_pri_d = best_pri_q;
    best_val_d = best_val_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    rd_addr    = '0;
    we         = 1'b0;
    wr_addr    = idx_q;
    wr_data    = rd_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          rsp_d.removed_value = '0;
          rsp_d.status        = STAT_OK;
          if (req_i.opcode == OP_INSERT) begin
            done_d = 1'b1;
            if (cnt_q == CNT_W'(DEPTH)) begin
              rsp_d.status = STAT_FULL;
            end else begin
              we           = 1'b1;
              wr_addr      = IDX_W'(cnt_q);
              wr_data.value = req_i.value;
              wr_data.prio  = req_i.priority_req;
              cnt_d        = CNT_W'(cnt_q + CNT_W'(1));
            end
            rsp_d.entry_count = cnt_d;
          end else if (cnt_q == '0) begin
            done_d            = 1'b1;
            rsp_d.status      = STAT_EMPTY;
            rsp_d.entry_count = cnt_q;
          end
        end
      end
      ST_SCAN: begin
        if (take) begin
          best_idx_d = idx_q;
          best_pri_d = rd_q.prio;
          best_val_d = rd_q.value;
        end
        if (last_scan) begin
          idx_d   = best_idx_d;
          rd_addr = IDX_W'(best_idx_d + IDX_W'(1));
        end else begin
          idx_d   = IDX_W'(idx_q + IDX_W'(1));
          rd_addr = IDX_W'(idx_q + IDX_W'(1));
        end
      end
      ST_SHIFT: begin
        rd_addr = IDX_W'(idx_q + IDX_W'(2));
        if (last_shift) begin
          cnt_d               = CNT_W'(cnt_q - CNT_W'(1));
          done_d              = 1'b1;
          rsp_d.status        = STAT_OK;
          rsp_d.removed_value = best_val_q;
          rsp_d.entry_count   = cnt_d;
        end else begin
          we    = 1'b1;
          idx_d = IDX_W'(idx_q + IDX_W'(1));
        end
      end
      default: ;
    endcase
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    best_idx_q <= best_idx_d;
    best_pri_q <= best_pri_d;
    best_val_q <= best_val_d;
    rsp_q      <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == STAT_EMPTY |-> rsp_o.entry_count == '0)
    else $error("empty status with nonzero count");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != STAT_OK |-> rsp_o.removed_value == '0)
    else $error("refused beat carries a value");

  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHIFT || state_q == ST_SCAN |-> cnt_q != '0)
    else $error("remove sequence on empty queue");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHIFT && last_shift |=> done_o && !busy)
    else $error("remove finished without result");

endmodule

/* verif/testbench.sv */
// self-checking testbench for the array priority queue: directed and random insert/remove beats vs a predictor
module testbench import apq_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 4;

  typedef struct {
    req_t        beat;
    int unsigned idle_pct;
    bit          drain;
  } send_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  send_item_t  beats_to_send[$];
  rsp_t        predicted_rsp[$];
  rsp_t        want_rsp;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // shadow copy of the queue contents
  logic signed [VAL_W-1:0] held_val[DEPTH];
  logic signed [PRI_W-1:0] held_pri[DEPTH];
  int unsigned             held_cnt = 0;

  // stimulus-side occupancy, used only to steer the directed fill and the random walk
  int unsigned gen_cnt = 0;

  array_priority_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic rsp_t pq_apply(req_t b);
    rsp_t        r;
    int unsigned best;
    int unsigned i;
    r.status        = STAT_OK;
    r.removed_value = '0;
    if (b.opcode == OP_INSERT) begin
      if (held_cnt >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        held_val[held_cnt] = b.value;
        held_pri[held_cnt] = b.priority_req;
        held_cnt++;
      end
    end else if (held_cnt == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      best = 0;
      for (i = 1; i < held_cnt; i++) begin
        if (held_pri[i] > held_pri[best]) best = i;
      end
      r.removed_value = held_val[best];
      for (i = best; i + 1 < held_cnt; i++) begin
        held_val[i] = held_val[i+1];
        held_pri[i] = held_pri[i+1];
      end
      held_cnt--;
    end
    r.entry_count = CNT_W'(held_cnt);
    return r;
  endfunction

  task automatic add_beat(op_e op, logic [VAL_W-1:0] v, logic [PRI_W-1:0] p,
                          int unsigned pct, bit drain);
    send_item_t it;
    it.beat.opcode       = op;
    it.beat.value        = v;
    it.beat.priority_req = p;
    it.idle_pct          = pct;
    it.drain             = drain;
    beats_to_send.push_back(it);
    if (op == OP_INSERT && gen_cnt < DEPTH) gen_cnt++;
    if (op == OP_REMOVE && gen_cnt > 0) gen_cnt--;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      if (start && !busy) begin
        predicted_rsp.push_back(pq_apply(beats_to_send[0].beat));
        void'(beats_to_send.pop_front());
        if (beats_to_send.size() == 0) begin
          start <= 1'b0;
        end else if (beats_to_send[0].drain && predicted_rsp.size() != 0) begin
          start <= 1'b0;
        end else if ($urandom_range(99) < beats_to_send[0].idle_pct) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          req_i <= beats_to_send[0].beat;
        end
      end else if (!start) begin
        if (beats_to_send.size() != 0 &&
            !(beats_to_send[0].drain && predicted_rsp.size() != 0) &&
            $urandom_range(99) >= beats_to_send[0].idle_pct) begin
          start <= 1'b1;
          req_i <= beats_to_send[0].beat;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (predicted_rsp.size() == 0) begin
        $display("%0t: unexpected result beat status %0d value %0d count %0d", $time,
                 rsp_o.status, rsp_o.removed_value, rsp_o.entry_count);
        mismatches++;
      end else begin
        want_rsp = predicted_rsp.pop_front();
        if (rsp_o.status !== want_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want_rsp.status, rsp_o.status);
          mismatches++;
        end
        if (rsp_o.removed_value !== want_rsp.removed_value) begin
          $display("%0t: removed_value expected %0d actual %0d", $time,
                   want_rsp.removed_value, rsp_o.removed_value);
          mismatches++;
        end
        if (rsp_o.entry_count !== want_rsp.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   want_rsp.entry_count, rsp_o.entry_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned      phase_pct[3];
    int unsigned      n;
    int unsigned      ph;
    bit               filling;
    op_e              op;
    logic [PRI_W-1:0] pri;
    phase_pct[0] = 16;
    phase_pct[1] = 80;
    phase_pct[2] = 0;
    filling      = 1'b1;

    // directed: empty remove, field extremes, tie order, fill to full
    add_beat(OP_REMOVE, $urandom, 16'($urandom), 16, 1'b0);
    add_beat(OP_INSERT, 32'h8000_0000, 16'h8000, 16, 1'b0);
    add_beat(OP_INSERT, 32'h7fff_ffff, 16'h7fff, 16, 1'b0);
    add_beat(OP_INSERT, 32'h0000_0000, 16'h0000, 16, 1'b0);
    add_beat(OP_INSERT, 32'hffff_ffff, 16'hffff, 16, 1'b0);
    add_beat(OP_INSERT, 32'd5, 16'd7, 16, 1'b0);
    add_beat(OP_INSERT, 32'd6, 16'd7, 16, 1'b0);
    add_beat(OP_REMOVE, 32'hffff_ffff, 16'hffff, 16, 1'b0);
    add_beat(OP_REMOVE, 32'h0000_0000, 16'h0000, 16, 1'b0);
    add_beat(OP_REMOVE, $urandom, 16'($urandom), 16, 1'b0);
    while (gen_cnt < DEPTH) add_beat(OP_INSERT, $urandom, 16'($urandom), 16, 1'b0);
    add_beat(OP_INSERT, 32'h7fff_ffff, 16'h7fff, 16, 1'b0);

    // random walk between empty and full, one block per idle setting
    for (ph = 0; ph < 3; ph++) begin
      for (n = 0; n < 342; n++) begin
        if (gen_cnt == DEPTH) filling = 1'b0;
        if (gen_cnt == 0) filling = 1'b1;
        op = ($urandom_range(99) < (filling ? 70 : 30)) ? OP_INSERT : OP_REMOVE;
        case ($urandom_range(3))
          0: pri = 16'($signed($urandom_range(6)) - 3);
          1: pri = $urandom_range(1) ? 16'h7fff : 16'h8000;
          default: pri = 16'($urandom);
        endcase
        add_beat(op, $urandom, pri, phase_pct[ph], n == 0 || $urandom_range(49) == 0);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_to_send.size() != 0 || predicted_rsp.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && predicted_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/apq_pkg.sv
rtl/core/array_priority_queue.sv
verif/testbench.sv
